[rtl/pba_pkg.sv]
// shared constants and helpers for the page bitmap allocator
`default_nettype none

package pba_pkg;

    localparam int PAGE_COUNT_DEFAULT = 65536;
    localparam int ADDR_PAGE_LIMIT    = 65536;

    localparam int ADDR_W     = 28;
    localparam int LEN_W      = 29;
    localparam int MODE_W     = 2;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_BYTES = 4096;
    localparam int SUM_W      = 30;
    localparam int END_W      = SUM_W - PAGE_SHIFT;
    localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;

    localparam int WORD_BITS = 64;
    localparam int BIT_IDX_W = 6;
    localparam int MAP_IDX_W = PAGE_NUM_W - BIT_IDX_W;
    localparam int MAP_WORDS_MAX = 1024;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_NO_PAGE = 1'b1;

    typedef logic [WORD_BITS-1:0] map_word_t;

    function automatic logic [BIT_IDX_W-1:0] onehot_index(input map_word_t onehot);
        logic [BIT_IDX_W-1:0] idx;
        map_word_t            sel;
        for (int k = 0; k < BIT_IDX_W; k++)
        begin
            for (int i = 0; i < WORD_BITS; i++)
            begin
                sel[i] = onehot[i] & ((i >> k) & 1) == 1;
            end
            idx[k] = |sel;
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

[rtl/pba_ram.sv]
// generic single-port ram with registered read
`default_nettype none

module pba_ram #(
    parameter int WIDTH = pba_pkg::WORD_BITS,
    parameter int DEPTH = pba_pkg::MAP_WORDS_MAX,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/page_bitmap_allocator_unit.sv]
// page bitmap allocator: one free bit per 4 KiB page, kept in a word ram
//
// input channel (in_valid/in_stall): mode, address, length. mode allocate
// takes the lowest free page, mode free / reserve marks every page touched
// by the byte range [address, address+length) free or used.
// output channel (out_valid/out_stall): one result per input transfer,
// page_address and status (1 = no free page).
// one item is worked on at a time. the map word ram is read and written
// back one word at a time in a read step and a check step; a range writes
// each touched word back in its check step, an allocate scans upward from
// the lowest word that may hold a free page and writes the found word back
// in an encode step; an empty range or undefined mode goes to the final step.
// after reset the block runs a clearing pass that writes one map word per
// cycle (ceil(min(PAGE_COUNT,65536)/64) words, 1024 by default) with
// in_stall high; every page then starts reserved.
// a finished result sits in the output register while the next transfer
// is accepted; a stalled receiver holds the block in its final step.
`default_nettype none

module page_bitmap_allocator_unit #(
    parameter int PAGE_COUNT = pba_pkg::PAGE_COUNT_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [pba_pkg::MODE_W-1:0]    mode,
    input  wire logic [pba_pkg::ADDR_W-1:0]    address,
    input  wire logic [pba_pkg::LEN_W-1:0]     length,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [pba_pkg::ADDR_W-1:0]    page_address,
    output logic                               status
);

    localparam int LIVE_PAGES = (PAGE_COUNT < pba_pkg::ADDR_PAGE_LIMIT) ?
                                PAGE_COUNT : pba_pkg::ADDR_PAGE_LIMIT;
    localparam int MAP_WORDS  = (LIVE_PAGES + pba_pkg::WORD_BITS - 1) / pba_pkg::WORD_BITS;
    localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W      = $clog2(MAP_WORDS + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_ENC   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam logic [CNT_W-1:0] WORDS_END  = CNT_W'(MAP_WORDS);
    localparam logic [CNT_W-1:0] WORDS_LAST = CNT_W'(MAP_WORDS - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] word_reg, word_next;
    logic [CNT_W-1:0] hint_reg, hint_next;
    logic             out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]                first_word_reg, first_word_next;
    logic [CNT_W-1:0]                last_word_reg, last_word_next;
    logic [pba_pkg::BIT_IDX_W-1:0]   first_lo_reg, first_lo_next;
    logic [pba_pkg::BIT_IDX_W-1:0]   last_hi_reg, last_hi_next;
    logic                            make_free_reg, make_free_next;
    logic                            is_alloc_reg, is_alloc_next;
    pba_pkg::map_word_t              low_reg, low_next;
    pba_pkg::map_word_t              wbits_reg, wbits_next;
    logic [pba_pkg::ADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic                            res_status_reg, res_status_next;
    logic [pba_pkg::ADDR_W-1:0]      page_address_reg;
    logic                            status_reg;
    logic                            out_load;

    logic                            ram_we;
    pba_pkg::map_word_t              ram_wdata;
    pba_pkg::map_word_t              ram_rdata;

    logic [pba_pkg::SUM_W-1:0]       sum_c;
    logic [pba_pkg::END_W-1:0]       end_raw_c;
    logic [pba_pkg::END_W-1:0]       end_c;
    logic [pba_pkg::END_W-1:0]       last_c;
    logic [pba_pkg::PAGE_NUM_W-1:0]  first_c;
    logic                            empty_c;
    logic [CNT_W-1:0]                first_word_c;
    logic [pba_pkg::BIT_IDX_W-1:0]   lo_c, hi_c;
    pba_pkg::map_word_t              mask_c;
    logic [pba_pkg::BIT_IDX_W-1:0]   bit_idx_c;

    pba_ram #(
        .WIDTH (pba_pkg::WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (word_reg[AW-1:0]),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // range bounds in pages, end clamped to the managed limit
    always_comb
    begin
        sum_c        = pba_pkg::SUM_W'(address) + pba_pkg::SUM_W'(length)
                     + pba_pkg::SUM_W'(pba_pkg::PAGE_BYTES - 1);
        end_raw_c    = sum_c[pba_pkg::SUM_W-1:pba_pkg::PAGE_SHIFT];
        end_c        = (end_raw_c > pba_pkg::END_W'(LIVE_PAGES)) ?
                       pba_pkg::END_W'(LIVE_PAGES) : end_raw_c;
        first_c      = address[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT];
        empty_c      = (length == '0) || (pba_pkg::END_W'(first_c) >= end_c);
        last_c       = end_c - pba_pkg::END_W'(1);
        first_word_c = CNT_W'(first_c[pba_pkg::PAGE_NUM_W-1:pba_pkg::BIT_IDX_W]);
    end

    // bit mask of the current word inside the range
    always_comb
    begin
        lo_c   = (word_reg == first_word_reg) ? first_lo_reg : '0;
        hi_c   = (word_reg == last_word_reg) ? last_hi_reg : '1;
        mask_c = ({pba_pkg::WORD_BITS{1'b1}} << lo_c)
               & ({pba_pkg::WORD_BITS{1'b1}} >> (~hi_c));
    end

    assign bit_idx_c = pba_pkg::onehot_index(low_reg);

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        hint_next       = hint_reg;
        out_valid_next  = out_valid_reg && out_stall;
        first_word_next = first_word_reg;
        last_word_next  = last_word_reg;
        first_lo_next   = first_lo_reg;
        last_hi_next    = last_hi_reg;
        make_free_next  = make_free_reg;
        is_alloc_next   = is_alloc_reg;
        low_next        = low_reg;
        wbits_next      = wbits_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_load        = 1'b0;
        ram_we          = 1'b0;
        ram_wdata       = wbits_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (word_reg == WORDS_LAST)
                begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + CNT_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_addr_next   = '0;
                    res_status_next = pba_pkg::STATUS_DONE;
                    case (mode)
                        pba_pkg::MODE_ALLOC:
                        begin
                            is_alloc_next = 1'b1;
                            if (hint_reg == WORDS_END)
                            begin
                                res_status_next = pba_pkg::STATUS_NO_PAGE;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                word_next  = hint_reg;
                                state_next = S_RD;
                            end
                        end
                        pba_pkg::MODE_FREE, pba_pkg::MODE_RESERVE:
                        begin
                            is_alloc_next   = 1'b0;
                            make_free_next  = (mode == pba_pkg::MODE_FREE);
                            first_word_next = first_word_c;
                            last_word_next  =
                                CNT_W'(last_c[pba_pkg::PAGE_NUM_W-1:pba_pkg::BIT_IDX_W]);
                            first_lo_next   = first_c[pba_pkg::BIT_IDX_W-1:0];
                            last_hi_next    = last_c[pba_pkg::BIT_IDX_W-1:0];
                            word_next       = first_word_c;
                            if (empty_c)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_RD;
                                if ((mode == pba_pkg::MODE_FREE) && (first_word_c < hint_reg))
                                begin
                                    hint_next = first_word_c;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (is_alloc_reg)
                begin
                    if (ram_rdata == '0)
                    begin
                        if (word_reg == WORDS_LAST)
                        begin
                            hint_next       = WORDS_END;
                            res_status_next = pba_pkg::STATUS_NO_PAGE;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            word_next  = word_reg + CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        low_next   = ram_rdata & (~ram_rdata + pba_pkg::map_word_t'(1));
                        wbits_next = ram_rdata & (ram_rdata - pba_pkg::map_word_t'(1));
                        hint_next  = word_reg;
                        state_next = S_ENC;
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = make_free_reg ? (ram_rdata | mask_c) : (ram_rdata & ~mask_c);
                    if (word_reg == last_word_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        word_next  = word_reg + CNT_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_ENC:
            begin
                ram_we        = 1'b1;
                ram_wdata     = wbits_reg;
                res_addr_next = {pba_pkg::MAP_IDX_W'(word_reg), bit_idx_c,
                                 pba_pkg::PAGE_SHIFT'(0)};
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            word_reg      <= '0;
            hint_reg      <= WORDS_END;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            hint_reg      <= hint_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_word_reg <= first_word_next;
        last_word_reg  <= last_word_next;
        first_lo_reg   <= first_lo_next;
        last_hi_reg    <= last_hi_next;
        make_free_reg  <= make_free_next;
        is_alloc_reg   <= is_alloc_next;
        low_reg        <= low_next;
        wbits_reg      <= wbits_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            page_address_reg <= res_addr_reg;
            status_reg       <= res_status_reg;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign page_address = page_address_reg;
    assign status       = status_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted transfer did not start work");

    a_hint_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        hint_reg <= WORDS_END)
        else $error("free word hint past map end");

    a_fail_no_address: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == pba_pkg::STATUS_NO_PAGE)) |-> (page_address == '0))
        else $error("failed allocation carries an address");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_CLEAR) || (state_reg == S_CHK) || (state_reg == S_ENC)))
        else $error("map write outside a write step");

    a_result_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == S_FIN))
        else $error("result shown without finishing an item");

endmodule

`default_nettype wire
